// ===== src/rsh_pkg.sv =====
// Shared types and constants of the RGB 3x3 sharpen block.
package rsh_pkg;

  // Configuration port.
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned WidthRegW   = 11;
  localparam int unsigned HeightRegW  = 13;
  localparam int unsigned WidthReset  = 1024;
  localparam int unsigned HeightReset = 768;

  // Row counters run one row past the last drain row.
  localparam int unsigned RowW = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One window column: row above, centre row, row below.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } tap_t;

  typedef struct packed {
    tap_t left;
    tap_t centre;
    tap_t right;
  } win_t;

  // One line store entry: the row two above and the row just above.
  typedef struct packed {
    pix_t older;
    pix_t prev;
  } line_t;

  // Per-request control decided at acceptance.
  typedef struct packed {
    logic have;   // request produces a result
    logic col0;   // input column is the first of its row
    logic col1;   // input column is the second of its row
    logic w1;     // frame is a single column wide
    logic top;    // result lies on the first row
    logic bot;    // result lies on the last row
    logic last;   // result is the final one of the frame
  } ctl_t;

endpackage

// ===== src/rsh_seq.sv =====
// Position counters, frame bookkeeping and configuration registers.
module rsh_seq #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rsh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsh_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                      step_i,
  input  rsh_pkg::op_e              op_i,
  output logic                      active_o,
  output logic [AW-1:0]             addr_o,
  output rsh_pkg::ctl_t             ctl_o
);
  import rsh_pkg::*;

  localparam int unsigned CW = (AW + 1 > WidthRegW) ? AW + 1 : WidthRegW;

  // Last column index for a raw width: zero acts as one, large values clamp.
  function automatic logic [AW-1:0] width_last(logic [WidthRegW-1:0] raw);
    logic [CW-1:0] w;
    w = CW'(raw);
    if (w == '0) w = CW'(1);
    if (w > CW'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    return AW'(w - CW'(1));
  endfunction

  function automatic logic [HeightRegW-1:0] height_last(logic [HeightRegW-1:0] raw);
    return (raw == '0) ? '0 : raw - HeightRegW'(1);
  endfunction

  logic [AW-1:0]         wl_q, x_q, x_d, ocol_q, ocol_d;
  logic [HeightRegW-1:0] hl_q;
  logic [RowW-1:0]       y_q, y_d, orow_q, orow_d, hl_ext;
  logic                  frame_done, cfg_hit, have, last, bot;

  assign hl_ext     = RowW'(hl_q);
  assign frame_done = y_q > hl_ext;
  assign active_o   = (op_i == OP_DRAIN) ? frame_done : !frame_done;
  assign have       = (y_q >= RowW'(2)) || (y_q == RowW'(1) && x_q != '0);
  assign bot        = orow_q >= hl_ext;
  assign last       = have && bot && (ocol_q >= wl_q);
  assign addr_o     = x_q;

  assign cfg_hit = cfg_we_i &&
                   (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT);

  always_comb begin
    ctl_o.have = have;
    ctl_o.col0 = (x_q == '0);
    ctl_o.col1 = (x_q == AW'(1));
    ctl_o.w1   = (wl_q == '0);
    ctl_o.top  = (orow_q == '0);
    ctl_o.bot  = bot;
    ctl_o.last = last;

    if (x_q >= wl_q) begin
      x_d = '0;
      y_d = y_q + RowW'(1);
    end else begin
      x_d = x_q + AW'(1);
      y_d = y_q;
    end

    if (ocol_q >= wl_q) begin
      ocol_d = '0;
      orow_d = orow_q + RowW'(1);
    end else begin
      ocol_d = ocol_q + AW'(1);
      orow_d = orow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= width_last(WidthRegW'(WidthReset));
      hl_q   <= height_last(HeightRegW'(HeightReset));
      x_q    <= '0;
      y_q    <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (cfg_hit) begin
      // Any register write starts a fresh frame.
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  wl_q <= width_last(cfg_data_i[WidthRegW-1:0]);
        CFG_IMAGE_HEIGHT: hl_q <= height_last(cfg_data_i[HeightRegW-1:0]);
        default: ;
      endcase
      x_q    <= '0;
      y_q    <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (step_i && active_o) begin
      if (last) begin
        x_q    <= '0;
        y_q    <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        x_q <= x_d;
        y_q <= y_d;
        if (have) begin
          ocol_q <= ocol_d;
          orow_q <= orow_d;
        end
      end
    end
  end

endmodule

// ===== src/rsh_line_mem.sv =====
// Line store memory with a bypass for a read that meets a write to the same entry.
module rsh_line_mem #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  rsh_pkg::line_t wr_data_i,
  output rsh_pkg::line_t rd_data_o
);
  import rsh_pkg::*;

  line_t mem [DEPTH];
  line_t rd_q, byp_q;
  logic  byp_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      byp_q <= wr_data_i;
    end
  end

  // The array returns the old entry when read and written in one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_sel_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_sel_q ? byp_q : rd_q;

endmodule

// ===== src/rsh_window.sv =====
// Window columns, write-back data and edge replication of the 3x3 neighborhood.
module rsh_window (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  rsh_pkg::ctl_t  ctl_i,
  input  rsh_pkg::pix_t  pix_i,
  input  rsh_pkg::line_t rd_data_i,
  output rsh_pkg::line_t wr_data_o,
  output rsh_pkg::win_t  sel_o
);
  import rsh_pkg::*;

  function automatic tap_t vfix(tap_t t, logic top, logic bot);
    tap_t r;
    r = t;
    if (top) r.top = t.mid;
    if (bot) r.bot = t.mid;
    return r;
  endfunction

  // prev1 is the newest column held, prev2 the one before it.
  tap_t prev1_q, prev2_q, col_new;
  win_t raw;

  always_comb begin
    col_new.top = rd_data_i.older;
    col_new.mid = rd_data_i.prev;
    col_new.bot = pix_i;

    wr_data_o.older = rd_data_i.prev;
    wr_data_o.prev  = pix_i;

    raw.centre = prev1_q;
    if (ctl_i.col0) begin
      // Right edge of the row before: the new column is not part of it.
      raw.right = prev1_q;
      raw.left  = ctl_i.w1 ? prev1_q : prev2_q;
    end else begin
      raw.right = col_new;
      raw.left  = ctl_i.col1 ? prev1_q : prev2_q;
    end

    sel_o.left   = vfix(raw.left, ctl_i.top, ctl_i.bot);
    sel_o.centre = vfix(raw.centre, ctl_i.top, ctl_i.bot);
    sel_o.right  = vfix(raw.right, ctl_i.top, ctl_i.bot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q <= '0;
      prev2_q <= '0;
    end else if (step_i) begin
      prev2_q <= prev1_q;
      prev1_q <= col_new;
    end
  end

endmodule

// ===== src/rsh_kernel.sv =====
// Sharpen arithmetic with its window register and the output register.
module rsh_kernel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  rsh_pkg::win_t win_i,
  input  logic          last_i,
  output logic          take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsh_pkg::out_t out_data_o
);
  import rsh_pkg::*;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  function automatic logic [7:0] chan(pix_t p, chan_e c);
    logic [7:0] v;
    unique case (c)
      CH_RED:   v = p.red;
      CH_GREEN: v = p.green;
      CH_BLUE:  v = p.blue;
      default:  v = p.blue;
    endcase
    return v;
  endfunction

  // Nine times the centre minus the eight neighbours, clamped to a byte.
  function automatic logic [7:0] sharpen(win_t w, chan_e c);
    logic [11:0] pos;
    logic [10:0] neg;
    logic [11:0] diff;
    pos  = {1'b0, chan(w.centre.mid, c), 3'b000} + 12'(chan(w.centre.mid, c));
    neg  = 11'(chan(w.left.top, c)) + 11'(chan(w.left.mid, c)) +
           11'(chan(w.left.bot, c)) + 11'(chan(w.centre.top, c)) +
           11'(chan(w.centre.bot, c)) + 11'(chan(w.right.top, c)) +
           11'(chan(w.right.mid, c)) + 11'(chan(w.right.bot, c));
    diff = pos - 12'(neg);
    if (pos <= 12'(neg)) return 8'd0;
    return (diff > 12'd255) ? 8'hFF : diff[7:0];
  endfunction

  win_t win_q;
  logic last_q, win_valid_q, out_en;

  assign out_en = !out_valid_o || out_ready_i;
  assign take_o = !win_valid_q || out_en;

  always_ff @(posedge clk_i) begin
    if (take_o && load_i) begin
      win_q  <= win_i;
      last_q <= last_i;
    end
    if (out_en && win_valid_q) begin
      out_data_o.red_out    <= sharpen(win_q, CH_RED);
      out_data_o.green_out  <= sharpen(win_q, CH_GREEN);
      out_data_o.blue_out   <= sharpen(win_q, CH_BLUE);
      out_data_o.frame_last <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (take_o) win_valid_q <= load_i;
      if (out_en) out_valid_o <= win_valid_q;
    end
  end

endmodule

// ===== src/rgb_sharpen_3x3.sv =====
// Top level of the streaming RGB 3x3 sharpen block.
//
// Pixels enter on the in channel in raster order, one request per pixel with
// operation set to pixel. Each channel is sharpened as nine times the centre
// minus the eight neighbours, with edge pixels replicated outward, and the
// sum is clamped to 0..255. A result belongs to the pixel one row plus one
// pixel earlier, so once a frame's pixels are in, image_width + 1 drain
// requests push the remaining results out; the final one carries frame_last
// and the block then waits for the next frame's first pixel.
// The block takes one request per cycle. Each request that touches the frame
// costs one line store read and one write, on separate cycles; its result
// passes the first stage, kernel window and output registers. A write that
// meets the next read of the same entry is bypassed. When the receiver stalls,
// results back up into the kernel register and only then does in_ready_o drop.
// Reset clears the counters and window and loads width 1024 and height 768;
// the line store holds no reset state and needs no clearing pass. The
// configuration channel is always ready; any size write restarts the frame.
module rgb_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rsh_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rsh_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rsh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rsh_pkg::CfgDataW-1:0] cfg_data_i
);
  import rsh_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic          acc, seq_active, rd_en, s1_go, s1_free, take;
  logic [AW-1:0] seq_addr;
  ctl_t          seq_ctl;
  pix_t          in_pix;
  line_t         rd_data, wr_data;
  win_t          sel;

  // The request that read the line store last cycle or earlier.
  logic          s1_valid_q;
  ctl_t          s1_ctl_q;
  logic [AW-1:0] s1_addr_q;
  pix_t          s1_pix_q;

  assign cfg_ready_o = 1'b1;

  // A request stays in the first stage only while its result cannot move on.
  assign s1_free    = !s1_valid_q || !s1_ctl_q.have || take;
  assign s1_go      = s1_valid_q && s1_free;
  assign in_ready_o = s1_free;
  assign acc        = in_valid_i && in_ready_o;
  assign rd_en      = acc && seq_active;

  // Drain requests shift a black pixel into the window and line store.
  always_comb begin
    if (in_data_i.operation == OP_DRAIN) begin
      in_pix = '0;
    end else begin
      in_pix.red   = in_data_i.red_in;
      in_pix.green = in_data_i.green_in;
      in_pix.blue  = in_data_i.blue_in;
    end
  end

  rsh_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (acc),
    .op_i        (in_data_i.operation),
    .active_o    (seq_active),
    .addr_o      (seq_addr),
    .ctl_o       (seq_ctl)
  );

  rsh_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (seq_addr),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_ctl_q  <= seq_ctl;
      s1_addr_q <= seq_addr;
      s1_pix_q  <= in_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= rd_en;
    end
  end

  rsh_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_go),
    .ctl_i     (s1_ctl_q),
    .pix_i     (s1_pix_q),
    .rd_data_i (rd_data),
    .wr_data_o (wr_data),
    .sel_o     (sel)
  );

  rsh_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_go && s1_ctl_q.have),
    .win_i       (sel),
    .last_i      (s1_ctl_q.last),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A request that touches the frame reaches the first stage on the next edge.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_valid_q)
    else $error("taken request did not reach the first stage");

  // Input backpressure only ever comes from a full output register.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output register could move");

endmodule

// ===== verif/tb_rgb_sharpen_3x3.sv =====
// Self-checking testbench for the rgb_sharpen_3x3 streaming sharpen block.
module tb_rgb_sharpen_3x3;
  import rsh_pkg::*;

  // The block is built at its default line length; the model's line stores match it.
  localparam int unsigned MaxWidth = 1024;
  // Results pass the first stage, kernel window and output registers, so a
  // request that produces nothing is surely finished after this many quiet cycles.
  localparam int unsigned SettleCycles = 8;
  // Cycles without any accepted request, result or register write before the run is
  // declared hung. The longest legal quiet stretch is the deliberate output hold.
  localparam int unsigned StuckLimit = 4000;
  // Well-formed random frames stop once this many requests have gone in.
  localparam int unsigned RandomItems = 480;
  localparam int unsigned HoldCycles = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rgb_sharpen_3x3 #(
    .MAX_WIDTH(MaxWidth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Model of the block: line stores, 3x3 window, position counters and the two
  // size registers. It is advanced once per accepted request and pushes every
  // sharpened pixel it predicts onto sharp_px_queue.
  // ---------------------------------------------------------------------------
  pix_t        row_above_mem [MaxWidth];
  pix_t        row_two_above_mem [MaxWidth];
  // Window column k occupies entries 3k..3k+2 (top, mid, bottom); column 0 is oldest.
  pix_t        window_px [9];
  int unsigned pix_col, pix_row, res_col, res_row;
  logic [WidthRegW-1:0]  width_setting;
  logic [HeightRegW-1:0] height_setting;
  out_t        sharp_px_queue [$];

  int unsigned bad_results;
  int unsigned frame_items;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned hold_left;

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_setting;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int chan_of(pix_t p, int unsigned sel);
    case (sel)
      0:       return int'(p.red);
      1:       return int'(p.green);
      default: return int'(p.blue);
    endcase
  endfunction

  // Nine times the centre minus the eight neighbours, clamped to a byte.
  function automatic logic [7:0] sharpen_chan(tap_t l, tap_t c, tap_t r, int unsigned sel);
    int acc;
    acc = 9 * chan_of(c.mid, sel) - chan_of(c.top, sel) - chan_of(c.bot, sel)
        - chan_of(l.top, sel) - chan_of(l.mid, sel) - chan_of(l.bot, sel)
        - chan_of(r.top, sel) - chan_of(r.mid, sel) - chan_of(r.bot, sel);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  function automatic void restart_frame();
    pix_col = 0;
    pix_row = 0;
    res_col = 0;
    res_row = 0;
  endfunction

  function automatic void sharpen_step(in_t req);
    int unsigned w, h, x, y;
    bit   have, at_end;
    tap_t l, c, r;
    out_t res;
    w = active_width();
    h = (height_setting == 0) ? 1 : int'(height_setting);
    x = pix_col;
    y = pix_row;
    l = '0;
    c = '0;
    r = '0;
    // A pixel after the frame's last row and a drain before it are dropped.
    if (req.operation == OP_PIXEL && y >= h) return;
    if (req.operation == OP_DRAIN && y < h) return;
    have = (y >= 2) || (y == 1 && x >= 1);
    // On a row start the result is the right edge of an earlier row, taken
    // from the window before the new column shifts in.
    if (have && x == 0) begin
      c = {window_px[6], window_px[7], window_px[8]};
      r = c;
      l = (w == 1) ? c : {window_px[3], window_px[4], window_px[5]};
    end
    for (int k = 0; k < 6; k++) window_px[k] = window_px[k + 3];
    window_px[6] = row_two_above_mem[x];
    window_px[7] = row_above_mem[x];
    if (req.operation == OP_PIXEL) begin
      window_px[8] = {req.red_in, req.green_in, req.blue_in};
    end else begin
      window_px[8] = '0;
    end
    row_two_above_mem[x] = window_px[7];
    row_above_mem[x] = window_px[8];
    if (have && x >= 1) begin
      c = {window_px[3], window_px[4], window_px[5]};
      r = {window_px[6], window_px[7], window_px[8]};
      l = (x == 1) ? c : {window_px[0], window_px[1], window_px[2]};
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
    end
    pix_col = x;
    pix_row = y;
    if (!have) return;
    // Replicate the first and last rows outward.
    if (res_row == 0) begin
      l.top = l.mid;
      c.top = c.mid;
      r.top = r.mid;
    end
    if (res_row >= h - 1) begin
      l.bot = l.mid;
      c.bot = c.mid;
      r.bot = r.mid;
    end
    res.red_out   = sharpen_chan(l, c, r, 0);
    res.green_out = sharpen_chan(l, c, r, 1);
    res.blue_out  = sharpen_chan(l, c, r, 2);
    at_end = (res_col >= w - 1) && (res_row >= h - 1);
    res.frame_last = at_end;
    sharp_px_queue.push_back(res);
    if (at_end) begin
      restart_frame();
    end else begin
      res_col++;
      if (res_col >= w) begin
        res_col = 0;
        res_row++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders.
  // ---------------------------------------------------------------------------
  function automatic in_t px_of(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    in_t req;
    req.operation = OP_PIXEL;
    req.red_in    = red;
    req.green_in  = green;
    req.blue_in   = blue;
    return req;
  endfunction

  // Style 0 is noise, style 1 saturated colors that push the clamp both ways,
  // style 2 a nearly flat image so that results land in the middle of the range.
  function automatic in_t make_pixel(int unsigned style);
    case (style)
      0:       return px_of(8'($urandom), 8'($urandom), 8'($urandom));
      1:       return px_of($urandom_range(0, 1) ? 8'hFF : 8'h00,
                            $urandom_range(0, 1) ? 8'hFF : 8'h00,
                            $urandom_range(0, 1) ? 8'hFF : 8'h00);
      default: return px_of(8'($urandom_range(96, 112)), 8'($urandom_range(96, 112)),
                            8'($urandom_range(96, 112)));
    endcase
  endfunction

  // The color fields of a drain request are ignored, so they carry noise.
  function automatic in_t make_drain();
    in_t req;
    req = px_of(8'($urandom), 8'($urandom), 8'($urandom));
    req.operation = OP_DRAIN;
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Requests go out in bursts of random length, separated by random
  // gaps while gaps_on is set; valid stays up between back-to-back requests.
  // The model is advanced at the edge where the request is taken.
  // ---------------------------------------------------------------------------
  task automatic push_request(in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
      gap = $urandom_range(1, 10);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sharpen_step(req);
  endtask

  // Stop sending, wait for every predicted pixel, then give requests that
  // produce nothing time to leave the pipeline.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sharp_px_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes only happen with the block idle. Any write restarts the frame.
  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_setting = WidthRegW'(value);
    end else begin
      height_setting = HeightRegW'(value);
    end
    restart_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: the receiver stalls in runs of its own, with long stretches of
  // steady ready, and can be told to hold off for a counted number of cycles.
  // ---------------------------------------------------------------------------
  initial begin : output_stall_pattern
    bit          ready_now;
    int unsigned run_left;
    ready_now   = 1'b0;
    run_left    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          ready_now = !ready_now;
          if (ready_now) begin
            run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                   : $urandom_range(1, 20);
          end else begin
            run_left = $urandom_range(1, 8);
          end
        end
        run_left--;
        out_ready_i <= ready_now;
      end
    end
  end

  task automatic note_bad(string what, logic [7:0] want, logic [7:0] got);
    bad_results++;
    if (bad_results <= 10) begin
      $display("ERROR at %0t: %s expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Every result taken is compared, field by field, with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sharp_px_queue.size() == 0) begin
        note_bad("result with none predicted, red", 8'h00, out_data_o.red_out);
      end else begin
        want = sharp_px_queue.pop_front();
        if (out_data_o.red_out !== want.red_out) begin
          note_bad("red_out", want.red_out, out_data_o.red_out);
        end
        if (out_data_o.green_out !== want.green_out) begin
          note_bad("green_out", want.green_out, out_data_o.green_out);
        end
        if (out_data_o.blue_out !== want.blue_out) begin
          note_bad("blue_out", want.blue_out, out_data_o.blue_out);
        end
        if (out_data_o.frame_last !== want.frame_last) begin
          note_bad("frame_last", 8'(want.frame_last), 8'(out_data_o.frame_last));
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no channel moves anything.
  initial begin : hang_watch
    int unsigned stuck;
    stuck = 0;
    while (stuck < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Out of reset the frame is 1024 x 768: early pixels give nothing, and a
  // drain before the frame is complete is dropped.
  task automatic test_reset_size();
    push_request(px_of(8'h00, 8'h00, 8'h00));
    push_request(px_of(8'hFF, 8'hFF, 8'hFF));
    push_request(make_drain());
  endtask

  // Width and height written as zero act as one. A one-pixel frame needs two
  // drains, the first of which yields nothing; a pixel after the frame's input
  // is complete is dropped, and so is a drain once the frame has restarted.
  task automatic test_single_pixel_frame();
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    push_request(px_of(8'hFF, 8'h00, 8'hFF));
    push_request(px_of(8'h00, 8'hFF, 8'h00));
    push_request(make_drain());
    push_request(make_drain());
    push_request(make_drain());
  endtask

  // A 2 x 2 pattern of full and empty pixels, a checkerboard in red and blue,
  // drives every channel to both ends of the clamp.
  task automatic test_clamp_limits();
    write_reg(CFG_IMAGE_WIDTH, 2);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    push_request(px_of(8'hFF, 8'hFF, 8'hFF));
    push_request(px_of(8'h00, 8'h00, 8'h00));
    push_request(px_of(8'h00, 8'hFF, 8'h00));
    push_request(px_of(8'hFF, 8'h00, 8'hFF));
    repeat (3) push_request(make_drain());
  endtask

  // A register write in the middle of a frame restarts it. Register values
  // with every bit set are then used: the width saturates at the line length.
  task automatic test_restart_mid_frame();
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    repeat (5) push_request(make_pixel(1));
    write_reg(CFG_IMAGE_HEIGHT, (1 << HeightRegW) - 1);
    write_reg(CFG_IMAGE_WIDTH, (1 << CfgDataW) - 1);
    repeat (3) push_request(make_pixel(0));
  endtask

  // Full-length rows in a tall frame: the first row writes every line store entry,
  // up to the top one, before the input wraps into the second.
  task automatic test_full_width_rows();
    write_reg(CFG_IMAGE_WIDTH, MaxWidth);
    write_reg(CFG_IMAGE_HEIGHT, 4096);
    repeat (MaxWidth + 8) push_request(make_pixel($urandom_range(0, 2)));
  endtask

  // The receiver holds off for a long stretch while pixels keep coming
  // back to back, so the block fills and must stall its input.
  task automatic test_output_hold();
    write_reg(CFG_IMAGE_WIDTH, 8);
    write_reg(CFG_IMAGE_HEIGHT, 6);
    gaps_on   = 1'b0;
    hold_left = HoldCycles;
    repeat (48) push_request(make_pixel(0));
    repeat (9) push_request(make_drain());
    gaps_on = 1'b1;
  endtask

  // Mostly complete frames of random size and content. Some frames are cut
  // short by the next register write, some carry a stray drain before the
  // end or a stray pixel after it, and some pause until every result is out.
  task automatic test_random_frames();
    int unsigned w, h, npx, style, stray_at, pause_at;
    bit cut_short, tail_pixel, tail_drain;
    while (frame_items < RandomItems) begin
      cut_short = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(20, 80);
          h = $urandom_range(1, 3);
        end
        1: begin
          // Tall frames are never finished; a few rows are enough.
          w = $urandom_range(1, 4);
          h = $urandom_range(9, 4096);
          cut_short = 1'b1;
        end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 8);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_IMAGE_WIDTH, w);
      end
      npx = w * h;
      if (cut_short) npx = $urandom_range(1, (npx < 60) ? npx : 60);
      style      = $urandom_range(0, 2);
      stray_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npx - 1) : npx;
      pause_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npx - 1) : npx;
      tail_pixel = ($urandom_range(0, 9) == 0);
      tail_drain = ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < npx; i++) begin
        if (i == stray_at) push_request(make_drain());
        if (i == pause_at) wait_quiet();
        push_request(make_pixel(style));
        frame_items++;
      end
      if (!cut_short) begin
        if (tail_pixel) push_request(make_pixel(0));
        repeat (w + 1) begin
          push_request(make_drain());
          frame_items++;
        end
        if (tail_drain) push_request(make_drain());
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    bad_results = 0;
    frame_items = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    hold_left   = 0;
    width_setting  = WidthRegW'(WidthReset);
    height_setting = HeightRegW'(HeightReset);
    for (int k = 0; k < MaxWidth; k++) begin
      row_above_mem[k]     = '0;
      row_two_above_mem[k] = '0;
    end
    for (int k = 0; k < 9; k++) window_px[k] = '0;
    restart_frame();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_size();
    test_single_pixel_frame();
    test_clamp_limits();
    test_restart_mid_frame();
    test_full_width_rows();
    test_output_hold();
    test_random_frames();
    wait_quiet();

    if (sharp_px_queue.size() != 0) begin
      note_bad("results still outstanding, count", 8'(sharp_px_queue.size()), 8'h00);
    end
    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rsh_pkg.sv
src/rsh_seq.sv
src/rsh_line_mem.sv
src/rsh_window.sv
src/rsh_kernel.sv
src/rgb_sharpen_3x3.sv
verif/tb_rgb_sharpen_3x3.sv
